/* rtl/stg_pkg.sv */
// ----------------------------------------------------------------------------
// stg_pkg: square tone generator shared definitions
// Widths, tone limits, command codes and the types passed between the
// front end, the item queue, the executor and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package stg_pkg;

  // Free-running tick counter width (16 to 32)
  localparam int unsigned COUNTER_BITS = 32;
  localparam int unsigned CNT_W        = COUNTER_BITS;

  // Item field widths
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned FREQ_W = 16;
  localparam int unsigned MS_W   = 16;

  // Tone state widths
  localparam int unsigned HALF_W = 15;
  localparam int unsigned TOG_W  = 22;

  // Divider: 32-bit dividend, 16-bit divisor, one quotient bit per cycle
  localparam int unsigned DIV_W      = 32;
  localparam int unsigned DSR_W      = 16;
  localparam int unsigned DIV_STEP_W = $clog2(DIV_W);

  // Tone limits and time base
  localparam int unsigned TICK_HZ  = 1000000;
  localparam int unsigned FREQ_MIN = 20;
  localparam int unsigned FREQ_MAX = 20000;
  localparam int unsigned MS_PER_S = 1000;

  // Toggle count 2*f*ms/1000 = (f*ms)/500: drop two bits of f*ms, then
  // divide by 125 with a scaled reciprocal (exact for a 29-bit operand)
  localparam int unsigned            TOG_PRE_SH   = 2;
  localparam int unsigned            TOG_Y_W      = 29;
  localparam int unsigned            TOG_RECIP_W  = 30;
  localparam logic [TOG_RECIP_W-1:0] TOG_RECIP    = 30'd549755814;
  localparam int unsigned            TOG_RECIP_SH = 36;

  // Item queue between front end and executor
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  // Classified operation carried through the queue
  typedef enum logic [1:0] {
    OP_NOP,
    OP_TICK,
    OP_START,
    OP_STOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   ms;
  } entry_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/stg_in_if.sv */
// ----------------------------------------------------------------------------
// stg_in_if: command channel
// Valid/ready channel carrying one command item with its tone settings.
// ----------------------------------------------------------------------------
`default_nettype none

interface stg_in_if;
  logic                         valid;
  logic                         ready;
  logic [stg_pkg::CMD_W-1:0]    cmd;
  logic [stg_pkg::FREQ_W-1:0]   tone_freq_hz;
  logic [stg_pkg::MS_W-1:0]     tone_ms;

  modport source (output valid, output cmd, output tone_freq_hz, output tone_ms,
                  input ready);
  modport sink   (input valid, input cmd, input tone_freq_hz, input tone_ms,
                  output ready);
endinterface

`default_nettype wire

/* rtl/stg_res_if.sv */
// ----------------------------------------------------------------------------
// stg_res_if: result channel
// Valid/ready channel carrying the output level and running flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface stg_res_if;
  logic valid;
  logic ready;
  logic tone_level;
  logic tone_running;

  modport source (output valid, output tone_level, output tone_running, input ready);
  modport sink   (input valid, input tone_level, input tone_running, output ready);
endinterface

`default_nettype wire

/* rtl/stg_front.sv */
// ----------------------------------------------------------------------------
// stg_front: command front end
// Accepts command items and classifies them into queue operations. Starts
// with a frequency outside the audible range become no-ops here.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_front (
  stg_in_if.sink          in_i,
  output logic            push_valid_o,
  output stg_pkg::entry_t push_entry_o,
  input  logic            push_ready_i
);

  logic freq_ok;

  // Check the start frequency window
  assign freq_ok = (in_i.tone_freq_hz >= stg_pkg::FREQ_W'(stg_pkg::FREQ_MIN)) &&
                   (in_i.tone_freq_hz <= stg_pkg::FREQ_W'(stg_pkg::FREQ_MAX));

  // Classify the command
  always_comb begin
    push_entry_o.freq = in_i.tone_freq_hz;
    push_entry_o.ms   = in_i.tone_ms;
    case (in_i.cmd)
      stg_pkg::CMD_TICK:  push_entry_o.op = stg_pkg::OP_TICK;
      stg_pkg::CMD_START: push_entry_o.op = freq_ok ? stg_pkg::OP_START : stg_pkg::OP_NOP;
      stg_pkg::CMD_STOP:  push_entry_o.op = stg_pkg::OP_STOP;
      default:            push_entry_o.op = stg_pkg::OP_NOP;
    endcase
  end

  // Transfer straight into the queue
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

`default_nettype wire

/* rtl/stg_queue.sv */
// ----------------------------------------------------------------------------
// stg_queue: classified item queue
// Small FIFO that decouples the front end from the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  stg_pkg::entry_t push_entry_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output stg_pkg::entry_t pop_entry_o,
  input  logic            pop_ready_i
);

  stg_pkg::entry_t              mem_q [stg_pkg::QDEPTH];
  logic [stg_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [stg_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [stg_pkg::QPTR_W:0]     count_q, count_d;
  logic                         do_push, do_pop;

  assign push_ready_o = (count_q != (stg_pkg::QPTR_W+1)'(stg_pkg::QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_entry_o  = mem_q[rd_ptr_q];

  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/stg_div.sv */
// ----------------------------------------------------------------------------
// stg_div: iterative divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle. Pulses
// done with the quotient once the last quotient bit is shifted in.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stg_pkg::div_req_t req_i,
  output stg_pkg::div_rsp_t rsp_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [stg_pkg::DIV_STEP_W-1:0] step_q;
  logic [stg_pkg::DSR_W:0]        rem_q;
  logic [stg_pkg::DIV_W-1:0]      quo_q;
  logic [stg_pkg::DSR_W-1:0]      dsr_q;
  logic [stg_pkg::DSR_W:0]        rem_sh;
  logic                           fits;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem_q[stg_pkg::DSR_W-1:0], quo_q[stg_pkg::DIV_W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dsr_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q  <= fits ? rem_sh - {1'b0, dsr_q} : rem_sh;
        quo_q  <= {quo_q[stg_pkg::DIV_W-2:0], fits};
        step_q <= step_q + 1'b1;
        if (step_q == stg_pkg::DIV_STEP_W'(stg_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/stg_back.sv */
// ----------------------------------------------------------------------------
// stg_back: tone executor
// Pops classified items, runs the counter and compare logic, works out the
// half period with the divider and the toggle count with a reciprocal
// multiply, and registers one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  input  stg_pkg::entry_t   pop_entry_i,
  output logic              pop_ready_o,
  output stg_pkg::div_req_t div_req_o,
  input  stg_pkg::div_rsp_t div_rsp_i,
  stg_res_if.source         res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HALF,
    S_CNT,
    S_APPLY
  } state_e;

  state_e                       state_q, state_d;
  logic [stg_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [stg_pkg::CNT_W-1:0]    cmp_q, cmp_d;
  logic [stg_pkg::HALF_W-1:0]   half_q, half_d;
  logic [stg_pkg::TOG_W-1:0]    tog_q, tog_d;
  logic                         endless_q, endless_d;
  logic                         level_q, level_d;
  logic [stg_pkg::FREQ_W-1:0]   freq_q, freq_d;
  logic [stg_pkg::MS_W-1:0]     ms_q, ms_d;
  logic [stg_pkg::HALF_W-1:0]   new_half_q, new_half_d;
  logic [stg_pkg::TOG_W-1:0]    new_tog_q, new_tog_d;
  logic [stg_pkg::DIV_W-1:0]    prod_q, prod_d;
  logic                         res_valid_q, res_valid_d;
  logic                         res_level_q, res_level_d;
  logic                         res_run_q, res_run_d;
  logic [stg_pkg::TOG_Y_W+stg_pkg::TOG_RECIP_W-1:0] tog_scaled;
  logic                         res_free;
  logic                         load_res;

  assign res_free    = !res_valid_q || res_o.ready;
  assign pop_ready_o = (state_q == S_IDLE) && res_free;

  // Scale (f*ms)/4 by the reciprocal of 125
  assign tog_scaled = prod_q[stg_pkg::TOG_PRE_SH +: stg_pkg::TOG_Y_W] * stg_pkg::TOG_RECIP;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmp_d       = cmp_q;
    half_d      = half_q;
    tog_d       = tog_q;
    endless_d   = endless_q;
    level_d     = level_q;
    freq_d      = freq_q;
    ms_d        = ms_q;
    new_half_d  = new_half_q;
    new_tog_d   = new_tog_q;
    prod_d      = prod_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_level_d = res_level_q;
    res_run_d   = res_run_q;
    load_res    = 1'b0;

    div_req_o.start    = 1'b0;
    div_req_o.dividend = stg_pkg::DIV_W'(stg_pkg::TICK_HZ);
    div_req_o.divisor  = {pop_entry_i.freq[stg_pkg::DSR_W-2:0], 1'b0};

    case (state_q)
      S_IDLE: begin
        if (pop_valid_i && res_free) begin
          case (pop_entry_i.op)
            stg_pkg::OP_TICK: begin
              // Advance the counter; toggle on a compare match
              cnt_d    = cnt_q + stg_pkg::CNT_W'(1);
              load_res = 1'b1;
              if ((half_q != '0) && (cnt_d == cmp_q)) begin
                level_d = !level_q;
                cmp_d   = cmp_q + stg_pkg::CNT_W'(half_q);
                if (!endless_q) begin
                  if (tog_q != '0) begin
                    tog_d = tog_q - 1'b1;
                  end else begin
                    half_d    = '0;
                    tog_d     = '0;
                    endless_d = 1'b0;
                  end
                end
              end
            end
            stg_pkg::OP_START: begin
              // Hold the settings and divide for the half period
              freq_d          = pop_entry_i.freq;
              ms_d            = pop_entry_i.ms;
              div_req_o.start = 1'b1;
              state_d         = S_HALF;
            end
            stg_pkg::OP_STOP: begin
              half_d    = '0;
              tog_d     = '0;
              endless_d = 1'b0;
              load_res  = 1'b1;
            end
            default: begin
              load_res = 1'b1;
            end
          endcase
        end
      end
      S_HALF: begin
        if (div_rsp_i.done) begin
          new_half_d = div_rsp_i.quotient[stg_pkg::HALF_W-1:0];
          prod_d     = freq_q * ms_q;
          new_tog_d  = '0;
          state_d    = (ms_q == '0) ? S_APPLY : S_CNT;
        end
      end
      S_CNT: begin
        // Take the toggle count from the scaled product
        new_tog_d = tog_scaled[stg_pkg::TOG_RECIP_SH +: stg_pkg::TOG_W];
        state_d   = S_APPLY;
      end
      S_APPLY: begin
        // Load the new tone once the result slot is free
        if (res_free) begin
          half_d    = new_half_q;
          tog_d     = new_tog_q;
          endless_d = (ms_q == '0);
          cmp_d     = cnt_q + stg_pkg::CNT_W'(new_half_q);
          load_res  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load_res) begin
      res_valid_d = 1'b1;
      res_level_d = level_d;
      res_run_d   = (half_d != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cmp_q       <= '0;
      half_q      <= '0;
      tog_q       <= '0;
      endless_q   <= 1'b0;
      level_q     <= 1'b0;
      freq_q      <= '0;
      ms_q        <= '0;
      new_half_q  <= '0;
      new_tog_q   <= '0;
      prod_q      <= '0;
      res_valid_q <= 1'b0;
      res_level_q <= 1'b0;
      res_run_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cmp_q       <= cmp_d;
      half_q      <= half_d;
      tog_q       <= tog_d;
      endless_q   <= endless_d;
      level_q     <= level_d;
      freq_q      <= freq_d;
      ms_q        <= ms_d;
      new_half_q  <= new_half_d;
      new_tog_q   <= new_tog_d;
      prod_q      <= prod_d;
      res_valid_q <= res_valid_d;
      res_level_q <= res_level_d;
      res_run_q   <= res_run_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.tone_level   = res_level_q;
  assign res_o.tone_running = res_run_q;

endmodule

`default_nettype wire

/* rtl/square_tone_generator.sv */
// ----------------------------------------------------------------------------
// square_tone_generator: single-channel square-wave tone generator
// Output-compare tone channel on a free-running microsecond tick counter.
// ----------------------------------------------------------------------------
// Each command item gives exactly one result with the output level and the
// running flag after that item. Tick, stop and unused commands are handled
// in the executor's idle state, so a stream of them runs at one item per
// cycle while the result channel does not stall. A start with an in-range
// frequency holds the executor from the idle state where it is taken,
// through the half period in the one-bit-per-cycle divider (32 steps and
// the done pulse), the toggle count by reciprocal multiplication (skipped
// when the duration is zero) and the load of the tone and the registered
// result. A four-entry queue keeps accepting commands while a start is
// worked out or a result waits to be taken.
`default_nettype none

module square_tone_generator (
  input  logic      clk_i,
  input  logic      rst_ni,
  stg_in_if.sink    in_i,
  stg_res_if.source res_o
);

  logic              push_valid;
  logic              push_ready;
  stg_pkg::entry_t   push_entry;
  logic              pop_valid;
  logic              pop_ready;
  stg_pkg::entry_t   pop_entry;
  stg_pkg::div_req_t div_req;
  stg_pkg::div_rsp_t div_rsp;

  stg_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  stg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  stg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  stg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_entry_i (pop_entry),
    .pop_ready_o (pop_ready),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

/* rtl/stg_checker.sv */
// ----------------------------------------------------------------------------
// stg_checker: port-level checks for the tone generator
// Watches both channels: result hold under stall, no result without an
// outstanding item, and a stopped channel keeps its output level.
// ----------------------------------------------------------------------------
`default_nettype none

module stg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic tone_level_i,
  input logic tone_running_i
);

  logic [3:0] pending_q;
  logic       prev_level_q;
  logic       prev_run_q;
  logic       seen_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Track outstanding items and the last transferred result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      prev_level_q <= 1'b0;
      prev_run_q   <= 1'b0;
      seen_q       <= 1'b0;
    end else begin
      pending_q <= pending_q + 4'(in_xfer) - 4'(out_xfer);
      if (out_xfer) begin
        prev_level_q <= tone_level_i;
        prev_run_q   <= tone_running_i;
        seen_q       <= 1'b1;
      end
    end
  end

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(tone_level_i) && $stable(tone_running_i))
    else $error("result changed while stalled");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 4'd0)
    else $error("result offered with no outstanding item");

  a_stopped_level_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_q && !prev_run_q |-> tone_level_i == prev_level_q)
    else $error("output level changed on a stopped channel");

endmodule

bind square_tone_generator stg_checker u_stg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .tone_level_i   (res_o.tone_level),
  .tone_running_i (res_o.tone_running)
);

`default_nettype wire
